// ===== hw/rtl/lps_pkg.sv =====
package lps_pkg;

   localparam int COORD_BITS     = 12;
   localparam int ERR_BITS       = COORD_BITS + 1;
   localparam int COLOR_BITS     = 16;
   localparam int REQ_DATA_BITS  = ((4 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS  = ((2 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;
   localparam int QUEUE_PTR_BITS = 1;
   localparam int QUEUE_DEPTH    = 1 << QUEUE_PTR_BITS;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [ERR_BITS-1:0]   err_type;
   typedef logic [COLOR_BITS-1:0] color_type;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      DIR_NONE  = 2'd0,
      DIR_PLUS  = 2'd1,
      DIR_MINUS = 2'd3
   } dir_type;

   typedef struct packed {
      op_type    op;
      coord_type start_x;
      coord_type start_y;
      coord_type abs_dx;
      coord_type abs_dy;
      dir_type   col_dir;
      dir_type   row_dir;
      coord_type major_dist;
   } cmd_type;

   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

   function automatic coord_type step_axis(coord_type pos, dir_type dir);
      coord_type result;
      unique case (dir)
         DIR_PLUS:  result = pos + coord_type'(1);
         DIR_MINUS: result = pos - coord_type'(1);
         default:   result = pos;
      endcase
      return result;
   endfunction

endpackage

// ===== hw/rtl/lps_front.sv =====
module lps_front
   import lps_pkg::*;
(
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic                     req_tuser,
   input  queue_status_type         q_status,
   output logic                     q_push,
   output cmd_type                  q_cmd
);

   coord_type sx, sy, ex, ey;
   coord_type dx, dy;
   dir_type   cdir, rdir;

   assign sx = req_tdata[COORD_BITS-1:0];
   assign sy = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign ex = req_tdata[3*COORD_BITS-1:2*COORD_BITS];
   assign ey = req_tdata[4*COORD_BITS-1:3*COORD_BITS];

   always_comb begin
      priority if (ex > sx) begin
         dx   = ex - sx;
         cdir = DIR_PLUS;
      end else if (ex == sx) begin
         dx   = '0;
         cdir = DIR_NONE;
      end else begin
         dx   = sx - ex;
         cdir = DIR_MINUS;
      end
      priority if (ey > sy) begin
         dy   = ey - sy;
         rdir = DIR_PLUS;
      end else if (ey == sy) begin
         dy   = '0;
         rdir = DIR_NONE;
      end else begin
         dy   = sy - ey;
         rdir = DIR_MINUS;
      end
   end

   assign req_tready         = !q_status.full;
   assign q_push             = req_tvalid && req_tready;
   assign q_cmd.op           = op_type'(req_tuser);
   assign q_cmd.start_x      = sx;
   assign q_cmd.start_y      = sy;
   assign q_cmd.abs_dx       = dx;
   assign q_cmd.abs_dy       = dy;
   assign q_cmd.col_dir      = cdir;
   assign q_cmd.row_dir      = rdir;
   assign q_cmd.major_dist   = (dx > dy) ? dx : dy;

endmodule

// ===== hw/rtl/lps_queue.sv =====
module lps_queue
   import lps_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_cmd,
   input  logic             pop,
   output cmd_type          head_cmd,
   output queue_status_type status
);

   cmd_type                      entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]      count_ff, count_in;
   logic                         do_pop;

   assign status.valid = count_ff != '0;
   assign status.full  = count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH);
   assign head_cmd     = entry_ff[rd_ptr_ff];
   assign do_pop       = pop && status.valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      unique case ({push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hw/rtl/lps_back.sv =====
module lps_back
   import lps_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [COLOR_BITS-1:0]    csr_wr_data,
   input  queue_status_type         q_status,
   input  cmd_type                  q_cmd,
   output logic                     q_pop,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                     rsp_tlast
);

   color_type color_ff;
   coord_type cur_col_ff, cur_col_in;
   coord_type cur_row_ff, cur_row_in;
   coord_type abs_dx_ff, abs_dx_in;
   coord_type abs_dy_ff, abs_dy_in;
   dir_type   col_dir_ff, col_dir_in;
   dir_type   row_dir_ff, row_dir_in;
   coord_type major_ff, major_in;
   err_type   col_err_ff, col_err_in;
   err_type   row_err_ff, row_err_in;
   err_type   emitted_ff, emitted_in;
   logic      busy_ff, busy_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic    out_ready, emit, last;
   err_type col_sum, row_sum, major_ext;

   assign out_ready = !rsp_valid_ff || rsp_tready;
   assign q_pop     = q_status.valid && out_ready;
   assign emit      = q_pop && (q_cmd.op == OP_STEP) && busy_ff;
   assign major_ext = {1'b0, major_ff};
   assign last      = emitted_ff == (major_ext + err_type'(1));
   assign col_sum   = col_err_ff + {1'b0, abs_dx_ff};
   assign row_sum   = row_err_ff + {1'b0, abs_dy_ff};

   always_comb begin
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      abs_dx_in    = abs_dx_ff;
      abs_dy_in    = abs_dy_ff;
      col_dir_in   = col_dir_ff;
      row_dir_in   = row_dir_ff;
      major_in     = major_ff;
      col_err_in   = col_err_ff;
      row_err_in   = row_err_ff;
      emitted_in   = emitted_ff;
      busy_in      = busy_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      if (q_pop && q_cmd.op == OP_LOAD) begin
         cur_col_in = q_cmd.start_x;
         cur_row_in = q_cmd.start_y;
         abs_dx_in  = q_cmd.abs_dx;
         abs_dy_in  = q_cmd.abs_dy;
         col_dir_in = q_cmd.col_dir;
         row_dir_in = q_cmd.row_dir;
         major_in   = q_cmd.major_dist;
         col_err_in = '0;
         row_err_in = '0;
         emitted_in = '0;
         busy_in    = 1'b1;
      end else if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_data_in[COORD_BITS-1:0]                           = cur_col_ff;
         rsp_data_in[2*COORD_BITS-1:COORD_BITS]                = cur_row_ff;
         rsp_data_in[2*COORD_BITS+COLOR_BITS-1:2*COORD_BITS]   = color_ff;
         rsp_last_in  = last;
         col_err_in   = col_sum;
         row_err_in   = row_sum;
         if (col_sum > major_ext) begin
            col_err_in = col_sum - major_ext;
            cur_col_in = step_axis(cur_col_ff, col_dir_ff);
         end
         if (row_sum > major_ext) begin
            row_err_in = row_sum - major_ext;
            cur_row_in = step_axis(cur_row_ff, row_dir_ff);
         end
         emitted_in = emitted_ff + err_type'(1);
         busy_in    = !last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff     <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            color_ff <= csr_wr_data;
         end
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_col_ff  <= cur_col_in;
      cur_row_ff  <= cur_row_in;
      abs_dx_ff   <= abs_dx_in;
      abs_dy_ff   <= abs_dy_in;
      col_dir_ff  <= col_dir_in;
      row_dir_ff  <= row_dir_in;
      major_ff    <= major_in;
      col_err_ff  <= col_err_in;
      row_err_ff  <= row_err_in;
      emitted_ff  <= emitted_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hw/rtl/line_pixel_stepper_unit.sv =====
// An accepted step word is queued; the back end then registers its pixel onto rsp.
// Throughput: one word per cycle in and one pixel per cycle out while rsp_tready
// is high, set by the stepping update in the back end behind a two-entry queue.
// Reset: synchronous, active high; empties the queue, drops any line, clears
// the output valid and sets the draw color to zero.
module line_pixel_stepper_unit
   import lps_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [COLOR_BITS-1:0]    csr_wr_data,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // start_x, start_y, end_x, end_y
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // op
   input  logic                     req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // pixel_x, pixel_y, pixel_color
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                     rsp_tlast
);

   queue_status_type q_status;
   cmd_type          push_cmd, head_cmd;
   logic             q_push, q_pop;

   lps_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   lps_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   lps_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_status    (q_status),
      .q_cmd       (head_cmd),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule
